// File: src/erm_pkg.sv
// Shared types and constants for the encoder speed meter.
// Used by erm_div and encoder_rpm_meter_top; no dependencies of its own.
`timescale 1ns / 1ps

package erm_pkg;

    localparam int STAMP_W  = 16;
    localparam int MINP_W   = 16;
    localparam int TPM_W    = 26;
    localparam int PPR_W    = 8;
    localparam int CFG_W    = 26;
    localparam int CFG_IDX_W = 2;
    localparam int SPEED_W  = 25;
    localparam int RING_DEPTH = 8;
    localparam int PTR_W    = $clog2(RING_DEPTH);
    localparam int SUM_W    = SPEED_W + PTR_W;
    localparam int FRAC_W   = 8;
    localparam int NUM_W    = TPM_W + FRAC_W;
    localparam int DEN_W    = STAMP_W + PPR_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    localparam logic [MINP_W-1:0] MIN_PERIOD_RST = MINP_W'(500);
    localparam logic [TPM_W-1:0]  TPM_RST        = TPM_W'(60000000);
    localparam logic [PPR_W-1:0]  PPR_RST        = PPR_W'(4);

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_MIN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_REV  = CFG_IDX_W'(2);

    localparam logic CMD_CAPTURE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// File: src/erm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on erm_pkg for operand widths and the status struct.
`timescale 1ns / 1ps

module erm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [erm_pkg::NUM_W-1:0]    i_num,
    input  logic [erm_pkg::DEN_W-1:0]    i_den,
    output logic [erm_pkg::NUM_W-1:0]    o_quot,
    output erm_pkg::t_div_status         o_status
);

    logic [erm_pkg::DEN_W-1:0]     r_rem;
    logic [erm_pkg::NUM_W-1:0]     r_quot;
    logic [erm_pkg::DEN_W-1:0]     r_den;
    logic [erm_pkg::DIV_CNT_W-1:0] r_count;
    logic                          r_busy;
    logic                          r_done;

    logic [erm_pkg::DEN_W:0] shifted;
    logic [erm_pkg::DEN_W:0] diff;
    logic                    ge;

    // A zero divisor always subtracts, which yields an all-ones quotient.
    assign shifted = {r_rem, r_quot[erm_pkg::NUM_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_count == '0);
            if (i_start) begin
                r_rem   <= '0;
                r_quot  <= i_num;
                r_den   <= i_den;
                r_count <= erm_pkg::DIV_CNT_W'(erm_pkg::NUM_W - 1);
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= ge ? diff[erm_pkg::DEN_W-1:0] : shifted[erm_pkg::DEN_W-1:0];
                r_quot <= {r_quot[erm_pkg::NUM_W-2:0], ge};
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    assign o_quot          = r_quot;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule

// File: src/encoder_rpm_meter_top.sv
// Period-based tachometer with an eight-entry moving average of speed.
// An accepted capture passes through a period step, a multiply, a divider start, the divider
// iterations, a ring update and a load before its result is valid. A rejected capture or a
// window tick goes from the first step straight to the load. One item is in work at a time;
// the next is taken after the result is loaded, and the load waits while the output stalls.
// Synchronous active-low reset restores register defaults and clears control and ring state.
`timescale 1ns / 1ps

module encoder_rpm_meter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [erm_pkg::STAMP_W-1:0]       i_capture_stamp,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [erm_pkg::SPEED_W-1:0]       o_avg_rpm,
    output logic [erm_pkg::STAMP_W-1:0]       o_period_ticks,
    output logic                              o_accepted,
    output logic                              o_stalled,
    input  logic                              i_cfg_wr_en,
    input  logic [erm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [erm_pkg::CFG_W-1:0]         i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV_START,
        S_DIV,
        S_RING,
        S_FINISH
    } t_state;

    t_state r_state;

    logic [erm_pkg::MINP_W-1:0]  r_min_period;
    logic [erm_pkg::TPM_W-1:0]   r_tpm;
    logic [erm_pkg::PPR_W-1:0]   r_ppr;

    logic                        r_cmd;
    logic [erm_pkg::STAMP_W-1:0] r_stamp;
    logic [erm_pkg::STAMP_W-1:0] r_last_stamp;
    logic [erm_pkg::STAMP_W-1:0] r_last_period;
    logic [erm_pkg::SPEED_W-1:0] r_ring [erm_pkg::RING_DEPTH];
    logic [erm_pkg::PTR_W-1:0]   r_ptr;
    logic [erm_pkg::SUM_W-1:0]   r_sum;
    logic                        r_pulse_seen;
    logic                        r_acc;
    logic                        r_stl;
    logic [erm_pkg::DEN_W-1:0]   r_den;

    logic                        r_out_valid;
    logic [erm_pkg::SPEED_W-1:0] r_out_avg;
    logic [erm_pkg::STAMP_W-1:0] r_out_period;
    logic                        r_out_acc;
    logic                        r_out_stl;

    logic [erm_pkg::STAMP_W-1:0] period;
    logic [erm_pkg::NUM_W-1:0]   quot;
    logic [erm_pkg::SPEED_W-1:0] speed;
    logic [erm_pkg::SPEED_W-1:0] old_speed;
    erm_pkg::t_div_status        div_status;
    logic                        div_start;

    assign period    = r_stamp - r_last_stamp;
    assign div_start = (r_state == S_DIV_START);
    assign speed     = (|quot[erm_pkg::NUM_W-1:erm_pkg::SPEED_W]) ? erm_pkg::SPEED_MAX
                                                                 : quot[erm_pkg::SPEED_W-1:0];
    assign old_speed = r_ring[r_ptr];

    erm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    ({r_tpm, {erm_pkg::FRAC_W{1'b0}}}),
        .i_den    (r_den),
        .o_quot   (quot),
        .o_status (div_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_min_period  <= erm_pkg::MIN_PERIOD_RST;
            r_tpm         <= erm_pkg::TPM_RST;
            r_ppr         <= erm_pkg::PPR_RST;
            r_last_stamp  <= '0;
            r_last_period <= '0;
            r_ptr         <= '0;
            r_sum         <= '0;
            r_pulse_seen  <= 1'b0;
            r_acc         <= 1'b0;
            r_stl         <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int k = 0; k < erm_pkg::RING_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    erm_pkg::REG_MIN_PERIOD: r_min_period <= i_cfg_wdata[erm_pkg::MINP_W-1:0];
                    erm_pkg::REG_TICKS_MIN:  r_tpm        <= i_cfg_wdata[erm_pkg::TPM_W-1:0];
                    erm_pkg::REG_PULSES_REV: r_ppr        <= i_cfg_wdata[erm_pkg::PPR_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_command;
                        r_stamp <= i_capture_stamp;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_cmd == erm_pkg::CMD_CAPTURE) begin
                        // The stamp and period advance even when the capture is a glitch.
                        r_stl         <= 1'b0;
                        r_last_stamp  <= r_stamp;
                        r_last_period <= period;
                        if (period > r_min_period) begin
                            r_acc   <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_acc   <= 1'b0;
                            r_state <= S_FINISH;
                        end
                    end else begin
                        r_acc <= 1'b0;
                        if (r_pulse_seen) begin
                            r_pulse_seen <= 1'b0;
                            r_stl        <= 1'b0;
                        end else begin
                            for (int k = 0; k < erm_pkg::RING_DEPTH; k++) begin
                                r_ring[k] <= '0;
                            end
                            r_sum         <= '0;
                            r_last_period <= '0;
                            r_stl         <= 1'b1;
                        end
                        r_state <= S_FINISH;
                    end
                end
                S_MUL: begin
                    r_den   <= r_last_period * r_ppr;
                    r_state <= S_DIV_START;
                end
                S_DIV_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_status.done) begin
                        r_state <= S_RING;
                    end
                end
                S_RING: begin
                    // The running sum swaps the oldest entry for the new speed.
                    r_ring[r_ptr] <= speed;
                    r_sum         <= r_sum - erm_pkg::SUM_W'(old_speed)
                                           + erm_pkg::SUM_W'(speed);
                    r_ptr         <= (r_ptr == erm_pkg::PTR_W'(erm_pkg::RING_DEPTH - 1))
                                     ? '0 : r_ptr + 1'b1;
                    r_pulse_seen  <= 1'b1;
                    r_state       <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_avg    <= r_sum[erm_pkg::SUM_W-1:erm_pkg::PTR_W];
                        r_out_period <= r_last_period;
                        r_out_acc    <= r_acc;
                        r_out_stl    <= r_stl;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_avg_rpm      = r_out_avg;
    assign o_period_ticks = r_out_period;
    assign o_accepted     = r_out_acc;
    assign o_stalled      = r_out_stl;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accepted && o_stalled))
        else $error("result reports both an accepted capture and a stall");

    a_stall_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stalled) |-> (o_avg_rpm == '0 && o_period_ticks == '0))
        else $error("stall result carries nonzero speed or period");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_status.busy || div_status.done) |-> (r_state == S_DIV))
        else $error("divider active outside the divide state");

    a_div_to_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_status.done) |=> (r_state == S_RING))
        else $error("divider result not taken into the ring");

endmodule
